// File: src/manl_pkg.sv
// Package: constants and helpers for the auto-normalizing mix limiter.
`default_nettype none
package manl_pkg;
    localparam int HALF_WAVE     = 32767;
    localparam int HISTORY_DEPTH = 64;
    localparam int FRAC_BITS     = 16;
    localparam int CEIL_W        = 36;
    localparam int HIST_AW       = $clog2(HISTORY_DEPTH);
    localparam int SEEN_W        = $clog2(HISTORY_DEPTH + 1);
    localparam int SAMPLE_W      = 19;
    localparam int MAG_W         = 19;
    localparam int NUM_W         = MAG_W + 15 + FRAC_BITS;
    localparam int REG_W         = 20;
    localparam int HOLD_W        = 21;
    localparam logic [CEIL_W-1:0] HALF_FIXED = CEIL_W'(HALF_WAVE) << FRAC_BITS;
    localparam logic [0:0] ADDR_HOLD = 1'b0;
    localparam logic [0:0] ADDR_FADE = 1'b1;
endpackage
`default_nettype wire

// File: src/mix_auto_normalizing_limiter.sv
// Top level of the auto-normalizing mix limiter with its shared divider and sequencer.
// Each division (fade step or output scaling) runs on one shared bit-serial divider, one
// quotient bit per cycle. History is a 64-entry memory with one registered read port.
// o_s_tready is low while an item is in work. An item whose sample neither exceeds nor
// follows an excess is scaled at once. An item whose sample raises the ceiling runs the
// 36-step fade-step division before the 50-step scaling. An item that rewrites j earlier
// samples, at most 63, first scans back through history and then rescales each of them
// before the current sample. The next item is taken only from the idle state.
`default_nettype none
module mix_auto_normalizing_limiter (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [23:0] i_s_tdata,  // [18:0] mixed_sample
    input  wire logic        i_s_tuser,  // sound_start
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [23:0]      o_m_tdata,  // [15:0] scaled_sample, [21:16] back_offset
    output logic             o_m_tlast,  // final_of_run
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    localparam int CW = manl_pkg::CEIL_W;
    localparam int NW = manl_pkg::NUM_W;
    localparam int AW = manl_pkg::HIST_AW;
    localparam int SW = manl_pkg::SEEN_W;
    localparam int XW = manl_pkg::SAMPLE_W;
    localparam int RW = manl_pkg::REG_W;
    localparam int HW = manl_pkg::HOLD_W;
    localparam logic [SW-1:0] DEPTH = SW'(manl_pkg::HISTORY_DEPTH);

    typedef enum logic [3:0] {
        S_IDLE, S_EXC, S_FSTEP, S_SCAN, S_SCANW, S_POS, S_RD, S_RDL, S_RDW, S_DIV, S_OUT,
        S_UPD
    } t_state;

    t_state r_state;
    logic [RW-1:0] r_hold_samples, r_fade_samples;
    logic [CW-1:0] r_ceiling, r_fade_step;
    logic [HW-1:0] r_hold_count;
    logic          r_exceeded_prev, r_exceed;
    logic [SW-1:0] r_seen;
    logic [AW-1:0] r_wptr;
    logic [XW-1:0] r_hist [manl_pkg::HISTORY_DEPTH];
    logic [XW-1:0] r_rdata, r_x;
    logic [AW-1:0] r_raddr;
    logic [SW-1:0] r_k, r_j;
    logic          r_pos;
    // divider
    logic [NW-1:0] r_num;
    logic [CW:0]   r_rem;
    logic [CW-1:0] r_den;
    logic [5:0]    r_cnt;
    logic          r_neg, r_div_fs;
    logic [CW-1:0] r_quot;
    logic          r_ovalid, r_olast;
    logic [15:0]   r_odata;
    logic [5:0]    r_ooff;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == manl_pkg::ADDR_FADE) ? 32'(r_fade_samples)
                                                      : 32'(r_hold_samples);
    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {2'b00, r_ooff, r_odata};
    assign o_m_tlast  = r_olast;

    logic [XW-1:0] x_in, mag_in;
    assign x_in   = i_s_tdata[XW-1:0];
    assign mag_in = x_in[XW-1] ? XW'(-x_in) : x_in;
    logic [XW-1:0] mag_x;
    assign mag_x = r_x[XW-1] ? XW'(-r_x) : r_x;
    logic [XW-1:0] mag_r;
    assign mag_r = r_rdata[XW-1] ? XW'(-r_rdata) : r_rdata;

    logic [CW:0] trial;
    assign trial = {r_rem[CW-1:0], r_num[NW-1]} - {1'b0, r_den};

    logic [CW-1:0] q_sat;
    logic [15:0]   scaled;
    always_comb begin
        q_sat = r_quot;
        if (r_neg) begin
            if (q_sat > CW'(32768)) q_sat = CW'(32768);
            scaled = 16'(17'h10000 - 17'(q_sat));
        end else begin
            if (q_sat > CW'(32767)) q_sat = CW'(32767);
            scaled = q_sat[15:0];
        end
    end

    logic [CW-1:0] ceil_faded;
    always_comb begin
        ceil_faded = r_ceiling;
        if (r_hold_count == '0 && r_ceiling > manl_pkg::HALF_FIXED) begin
            if (r_ceiling - manl_pkg::HALF_FIXED > r_fade_step)
                ceil_faded = r_ceiling - r_fade_step;
            else
                ceil_faded = manl_pkg::HALF_FIXED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_UPD) r_hist[r_wptr] <= r_x;
        r_rdata <= r_hist[r_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_hold_samples <= RW'(44100);
            r_fade_samples <= RW'(44100);
            r_ceiling <= manl_pkg::HALF_FIXED;
            r_fade_step <= '0;
            r_hold_count <= '0;
            r_exceeded_prev <= 1'b0;
            r_seen <= '0;
            r_wptr <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (psel && penable && pwrite) begin
                if (paddr[2] == manl_pkg::ADDR_HOLD) r_hold_samples <= pwdata[RW-1:0];
                else r_fade_samples <= pwdata[RW-1:0];
            end
            if (r_ovalid && i_m_tready && r_state != S_OUT) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_x <= x_in;
                        if (i_s_tuser) begin
                            r_ceiling <= manl_pkg::HALF_FIXED;
                            r_fade_step <= '0;
                            r_hold_count <= '0;
                            r_exceeded_prev <= 1'b0;
                            r_seen <= '0;
                        end
                        r_exceed <= (x_in != '0 &&
                            (CW'(mag_in) << manl_pkg::FRAC_BITS) >=
                            (i_s_tuser ? manl_pkg::HALF_FIXED : r_ceiling));
                        r_state <= S_EXC;
                    end
                end
                S_EXC: begin
                    if (r_exceed) begin
                        r_ceiling <= CW'(mag_x) << manl_pkg::FRAC_BITS;
                        r_hold_count <= HW'(r_hold_samples);
                        r_num <= NW'((CW'(mag_x) << manl_pkg::FRAC_BITS)
                                     - manl_pkg::HALF_FIXED) << (NW - CW);
                        r_den <= (r_fade_samples == '0) ? CW'(1) : CW'(r_fade_samples);
                        r_rem <= '0; r_cnt <= 6'(CW); r_quot <= '0;
                        r_div_fs <= 1'b1;
                        r_state <= S_DIV;
                    end else if (r_exceeded_prev && r_seen != '0) begin
                        r_k <= SW'(1);
                        r_raddr <= r_wptr - AW'(1);
                        r_state <= S_SCANW;
                    end else begin
                        r_state <= S_FSTEP;
                    end
                end
                S_SCANW: begin
                    r_raddr <= r_wptr - AW'(2);
                    r_state <= S_POS;
                end
                S_POS: begin
                    // r_rdata is the sample one back
                    r_pos <= ~r_rdata[XW-1] && r_rdata != '0;
                    r_raddr <= r_wptr - AW'(3);
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    // r_rdata is sample r_k+1 back, when available
                    if (r_k + SW'(1) > r_seen) begin
                        r_j <= r_k;
                        r_hold_count <= (HW'(r_hold_samples) > HW'(r_k))
                                        ? HW'(r_hold_samples) - HW'(r_k) : '0;
                        r_state <= S_RD;
                    end else if (r_k + SW'(1) >= DEPTH - SW'(1)) begin
                        r_j <= DEPTH - SW'(1);
                        r_hold_count <= (HW'(r_hold_samples) > HW'(DEPTH - SW'(2)))
                                        ? HW'(r_hold_samples) - HW'(DEPTH - SW'(2)) : '0;
                        r_state <= S_RD;
                    end else if (r_pos ? (~r_rdata[XW-1] && r_rdata != '0)
                                       : r_rdata[XW-1]) begin
                        // step back; keep the read address two samples ahead
                        r_k <= r_k + SW'(1);
                        r_raddr <= r_wptr - AW'(r_k + SW'(3));
                    end else begin
                        r_j <= r_k + SW'(1);
                        r_hold_count <= (HW'(r_hold_samples) > HW'(r_k))
                                        ? HW'(r_hold_samples) - HW'(r_k) : '0;
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    r_raddr <= r_wptr - r_j[AW-1:0];
                    r_state <= S_RDL;
                end
                S_RDL: begin
                    r_state <= S_RDW;
                end
                S_RDW: begin
                    r_state <= S_DIV;
                    r_div_fs <= 1'b0;
                    r_rem <= '0; r_cnt <= 6'(NW); r_quot <= '0;
                    r_den <= r_ceiling;
                    if (r_j == '0) begin
                        r_neg <= r_x[XW-1];
                        r_num <= NW'(NW'(mag_x) * NW'(manl_pkg::HALF_WAVE))
                                 << manl_pkg::FRAC_BITS;
                    end else begin
                        r_neg <= r_rdata[XW-1];
                        r_num <= NW'(NW'(mag_r) * NW'(manl_pkg::HALF_WAVE))
                                 << manl_pkg::FRAC_BITS;
                    end
                end
                S_DIV: begin
                    if (r_cnt == '0) begin
                        if (r_div_fs) begin
                            r_fade_step <= r_quot;
                            r_state <= S_FSTEP;
                        end else begin
                            r_state <= S_OUT;
                        end
                    end else begin
                        r_num <= r_num << 1;
                        r_cnt <= r_cnt - 6'd1;
                        if (!trial[CW]) begin
                            r_rem <= trial;
                            r_quot <= {r_quot[CW-2:0], 1'b1};
                        end else begin
                            r_rem <= {r_rem[CW-1:0], r_num[NW-1]};
                            r_quot <= {r_quot[CW-2:0], 1'b0};
                        end
                    end
                end
                S_FSTEP: begin
                    // apply hold countdown or fade, then scale the current sample
                    if (r_hold_count != '0) r_hold_count <= r_hold_count - HW'(1);
                    r_ceiling <= ceil_faded;
                    r_j <= '0;
                    r_state <= S_RDW;
                end
                S_OUT: begin
                    if (!r_ovalid || i_m_tready) begin
                        r_ovalid <= 1'b1;
                        r_odata <= scaled;
                        r_ooff <= r_j[5:0];
                        r_olast <= (r_j == '0);
                        if (r_j == '0) begin
                            r_state <= S_UPD;
                        end else if (r_j == SW'(1)) begin
                            r_state <= S_FSTEP;
                        end else begin
                            r_j <= r_j - SW'(1);
                            r_state <= S_RD;
                        end
                    end
                end
                S_UPD: begin
                    r_exceeded_prev <= r_exceed;
                    r_wptr <= r_wptr + AW'(1);
                    if (r_seen < DEPTH) r_seen <= r_seen + SW'(1);
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire
